// ----- rtl/core/clock_alarm_setting_controller_core_assert.svh -----
// ---------------------------------------------------------------------------
// Clock and alarm setter assertion macros
// Shorthand for the clocked, reset-gated checks used in the core.
// ---------------------------------------------------------------------------
`ifndef CLOCK_ALARM_SETTING_CONTROLLER_CORE_ASSERT_SVH
`define CLOCK_ALARM_SETTING_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CASC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CASC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/casc_pkg.sv -----
// ---------------------------------------------------------------------------
// Clock and alarm setter package
// Event codes, edit modes, action codes, field bounds and payload layouts.
// ---------------------------------------------------------------------------
package casc_pkg;

	typedef enum logic [2:0] {
		CMD_MODE  = 3'd0,
		CMD_OK    = 3'd1,
		CMD_MINUS = 3'd2,
		CMD_PLUS  = 3'd3,
		CMD_TICK  = 3'd4,
		CMD_MATCH = 3'd5,
		CMD_BUZZ  = 3'd6
	} cmd_t;

	typedef enum logic [3:0] {
		MODE_NORMAL  = 4'd0,
		MODE_AL_HOUR = 4'd1,
		MODE_AL_MIN  = 4'd2,
		MODE_AL_SEC  = 4'd3,
		MODE_HOUR    = 4'd4,
		MODE_MIN     = 4'd5,
		MODE_SEC     = 4'd6,
		MODE_YEAR    = 4'd7,
		MODE_MONTH   = 4'd8,
		MODE_DAY     = 4'd9,
		MODE_WEEKDAY = 4'd10,
		MODE_RING    = 4'd11
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_WR_TIME  = 3'd1,
		ACT_WR_ALARM = 3'd2,
		ACT_BUZZ_ON  = 3'd3,
		ACT_BUZZ_OFF = 3'd4
	} action_t;

	// Field bounds, all held at the width of the widest field.
	localparam logic [6:0] LO_ZERO   = 7'd0;
	localparam logic [6:0] LO_ONE    = 7'd1;
	localparam logic [6:0] HOUR_MAX  = 7'd23;
	localparam logic [6:0] MIN_MAX   = 7'd59;
	localparam logic [6:0] YEAR_MAX  = 7'd99;
	localparam logic [6:0] MONTH_MAX = 7'd12;
	localparam logic [6:0] DAY_MAX   = 7'd31;
	localparam logic [6:0] WDAY_MAX  = 7'd7;

	// Calendar fields, hours in the lowest bits.
	typedef struct packed {
		logic [2:0] weekday;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
	} cal_t;

	// Calendar after reset: midnight, with month, day and weekday at one.
	localparam cal_t CAL_RESET = '{weekday: 3'd1, day: 5'd1, month: 4'd1, year: 7'd0,
		seconds: 6'd0, minutes: 6'd0, hours: 5'd0};

	typedef struct packed {
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
	} alm_t;

	// Result item, edit mode in the lowest bits.
	typedef struct packed {
		action_t action;
		alm_t    alarm;
		cal_t    cal;
		mode_t   mode;
	} out_t;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 64;

	// One step of a field: up wraps past the top to the bottom, down wraps
	// from the bottom (or any value above the top) to the top.
	function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
		input logic [6:0] hi, input logic up);
		logic [6:0] r;
		if (up) begin
			r = (v >= hi) ? lo : v + 7'd1;
		end else begin
			r = (v <= lo || v > hi) ? hi : v - 7'd1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/clock_alarm_setting_controller_core.sv -----
// ---------------------------------------------------------------------------
// Clock and alarm setting controller core
// Event-driven editor for clock time, date and alarm, with buzzer control.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: RTC time and date snapshot
// m_axis    out        tdata: edit mode, shown time/date, alarm, action
//
// One item is taken per cycle unless both registers are full under an output
// stall, and every item yields exactly one result item. An accepted item is
// held in the input register; the short decode and field wrap logic then
// updates the clock state and fills the result register, from which the
// result is offered on m_axis.
// The controller state is updated only when an item leaves the input
// register, so items are handled strictly in order.
// When the result register is full and m_axis_tready is low, the input
// register holds its item and s_axis_tready drops once both are full.
// Reset clears the mode, the clock and alarm fields (month, day and weekday
// to one), the buzzer level and both valid flags.
// ---------------------------------------------------------------------------
`include "clock_alarm_setting_controller_core_assert.svh"

module clock_alarm_setting_controller_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// Fields from bit 0: now_hours(5), now_minutes(6), now_seconds(6),
	// now_year(7), now_month(4), now_day(5), now_weekday(3), zero fill(4).
	input  logic [casc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// Fields from bit 0: cmd(3).
	input  logic [2:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// Fields from bit 0: edit_mode(4), shown_hours(5), shown_minutes(6),
	// shown_seconds(6), shown_year(7), shown_month(4), shown_day(5),
	// shown_weekday(3), set_alarm_hours(5), set_alarm_minutes(6),
	// set_alarm_seconds(6), action(3), zero fill(4).
	output logic [casc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	import casc_pkg::*;

	// Input register.
	logic  valid_s1;
	cmd_t  cmd_s1;
	cal_t  snap_s1;

	// Controller state.
	mode_t mode_q;
	cal_t  cal_q;
	alm_t  alm_q;
	logic  buzz_q;

	// Result register.
	logic  out_valid_q;
	out_t  out_q;

	// Next state from the item in the input register.
	mode_t   mode_n;
	cal_t    cal_n;
	alm_t    alm_n;
	logic    buzz_n;
	action_t act_n;
	logic    load_snap;
	logic    step_up;
	logic    advance;

	// The item in the input register moves on whenever the result register
	// is empty or is being emptied in this cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			snap_s1 <= cal_t'(s_axis_tdata[$bits(cal_t)-1:0]);
		end
	end

	// Event decode. Minus and plus step only the field that the current edit
	// mode selects; OK commits and returns to normal mode; a second tick
	// refreshes the shown time except while time or date is being edited.
	always_comb begin
		mode_n    = mode_q;
		cal_n     = cal_q;
		alm_n     = alm_q;
		buzz_n    = buzz_q;
		act_n     = ACT_NONE;
		load_snap = 1'b0;
		step_up   = (cmd_s1 == CMD_PLUS);
		case (cmd_s1)
			CMD_MODE: begin
				// The last date field and the ringing mode both go back to
				// the alarm hour.
				if (mode_q >= MODE_WEEKDAY) begin
					mode_n = MODE_AL_HOUR;
				end else begin
					mode_n = mode_t'(mode_q + 4'd1);
				end
			end
			CMD_OK: begin
				if (mode_q >= MODE_AL_HOUR && mode_q <= MODE_AL_SEC) begin
					act_n     = ACT_WR_ALARM;
					load_snap = 1'b1;
				end else if (mode_q >= MODE_HOUR && mode_q <= MODE_WEEKDAY) begin
					// The edited time is what gets written, so keep it.
					act_n = ACT_WR_TIME;
				end else begin
					load_snap = 1'b1;
				end
				mode_n = MODE_NORMAL;
			end
			CMD_MINUS, CMD_PLUS: begin
				case (mode_q)
					MODE_AL_HOUR: alm_n.hours = 5'(wrap_step(7'(alm_q.hours),
						LO_ZERO, HOUR_MAX, step_up));
					MODE_AL_MIN: alm_n.minutes = 6'(wrap_step(7'(alm_q.minutes),
						LO_ZERO, MIN_MAX, step_up));
					MODE_AL_SEC: alm_n.seconds = 6'(wrap_step(7'(alm_q.seconds),
						LO_ZERO, MIN_MAX, step_up));
					MODE_HOUR: cal_n.hours = 5'(wrap_step(7'(cal_q.hours),
						LO_ZERO, HOUR_MAX, step_up));
					MODE_MIN: cal_n.minutes = 6'(wrap_step(7'(cal_q.minutes),
						LO_ZERO, MIN_MAX, step_up));
					MODE_SEC: cal_n.seconds = 6'(wrap_step(7'(cal_q.seconds),
						LO_ZERO, MIN_MAX, step_up));
					MODE_YEAR: cal_n.year = wrap_step(cal_q.year,
						LO_ZERO, YEAR_MAX, step_up);
					MODE_MONTH: cal_n.month = 4'(wrap_step(7'(cal_q.month),
						LO_ONE, MONTH_MAX, step_up));
					MODE_DAY: cal_n.day = 5'(wrap_step(7'(cal_q.day),
						LO_ONE, DAY_MAX, step_up));
					MODE_WEEKDAY: cal_n.weekday = 3'(wrap_step(7'(cal_q.weekday),
						LO_ONE, WDAY_MAX, step_up));
					default: begin
					end
				endcase
			end
			CMD_TICK: begin
				if (mode_q <= MODE_AL_SEC || mode_q == MODE_RING) begin
					load_snap = 1'b1;
				end
			end
			CMD_MATCH: begin
				mode_n = MODE_RING;
			end
			CMD_BUZZ: begin
				// While ringing the buzzer toggles on each buzz event; otherwise
				// it is forced off.
				if (mode_q == MODE_RING) begin
					buzz_n = !buzz_q;
					act_n  = buzz_n ? ACT_BUZZ_ON : ACT_BUZZ_OFF;
				end else begin
					buzz_n = 1'b0;
					act_n  = ACT_BUZZ_OFF;
				end
			end
			default: begin
			end
		endcase
		if (load_snap) begin
			cal_n = snap_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			cal_q       <= CAL_RESET;
			alm_q       <= '0;
			buzz_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q <= mode_n;
				cal_q  <= cal_n;
				alm_q  <= alm_n;
				buzz_q <= buzz_n;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.action <= act_n;
			out_q.alarm  <= alm_n;
			out_q.cal    <= cal_n;
			out_q.mode   <= mode_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - $bits(out_t))'(0), out_q};

	// A committed alarm always leaves the editor in normal mode.
	`CASC_ASSERT_SAME(a_alarm_commit_normal, out_valid_q && out_q.action == ACT_WR_ALARM,
		out_q.mode == MODE_NORMAL, "alarm write without return to normal mode")
	// The buzzer is only switched on while the alarm rings.
	`CASC_ASSERT_SAME(a_buzz_on_ringing, out_valid_q && out_q.action == ACT_BUZZ_ON,
		out_q.mode == MODE_RING && buzz_q, "buzzer on outside ringing mode")
	// While a result is stalled, the controller state must not move.
	`CASC_ASSERT_NEXT(a_stall_holds_state, out_valid_q && !m_axis_tready,
		$stable(mode_q) && $stable(cal_q) && $stable(alm_q), "state changed during stall")

endmodule

// ----- test/tb_clock_alarm_setting_controller_core.sv -----
// ---------------------------------------------------------------------------
// Clock and alarm setter core testbench
// Drives key, tick, match and buzzer events into the core with random
// stalls on both streams, predicts every result item in a cycle-free model
// of the controller state and compares each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_clock_alarm_setting_controller_core;
	import casc_pkg::*;

	// The event code that the core has no use for; it must leave all state alone.
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	localparam int TOTAL_ITEMS = 1450;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PRESSURE_AT = 400;
	localparam int PRESSURE_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// One input item: the event code and the RTC snapshot that rides with it.
	typedef struct packed {
		logic [2:0] cmd;
		cal_t       snap;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Items waiting to be offered, and results predicted but not yet seen.
	key_event_t key_events[$];
	out_t expected_displays[$];

	// Shadow copy of the controller state.
	mode_t cur_mode = MODE_NORMAL;
	cal_t clock_fields;
	alm_t alarm_fields = '0;
	bit buzzer_on = 1'b0;

	int unsigned cycle_count = 0;
	int mismatches = 0;
	int results_seen = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit pressure_done = 1'b0;
	key_event_t taken;
	key_event_t next_ev;
	out_t got;
	out_t want;

	clock_alarm_setting_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial forever #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// One press of plus or minus on a field bounded by lo and hi. Plus from
	// the top, or from anything above it, lands on the bottom. Minus from the
	// bottom, or from anything out of range above, lands on the top.
	function automatic logic [6:0] step_value(logic [6:0] v, logic [6:0] lo,
		logic [6:0] hi, bit up);
		if (up)
			return (v >= hi) ? lo : v + 7'd1;
		return (v <= lo || v > hi) ? hi : v - 7'd1;
	endfunction

	// Plus and minus act on the field that the edit mode selects; normal and
	// ringing modes have no field, so the keys are ignored there.
	function automatic void nudge_field(bit up);
		case (cur_mode)
			MODE_AL_HOUR: alarm_fields.hours = 5'(step_value(7'(alarm_fields.hours),
				LO_ZERO, HOUR_MAX, up));
			MODE_AL_MIN: alarm_fields.minutes = 6'(step_value(7'(alarm_fields.minutes),
				LO_ZERO, MIN_MAX, up));
			MODE_AL_SEC: alarm_fields.seconds = 6'(step_value(7'(alarm_fields.seconds),
				LO_ZERO, MIN_MAX, up));
			MODE_HOUR: clock_fields.hours = 5'(step_value(7'(clock_fields.hours),
				LO_ZERO, HOUR_MAX, up));
			MODE_MIN: clock_fields.minutes = 6'(step_value(7'(clock_fields.minutes),
				LO_ZERO, MIN_MAX, up));
			MODE_SEC: clock_fields.seconds = 6'(step_value(7'(clock_fields.seconds),
				LO_ZERO, MIN_MAX, up));
			MODE_YEAR: clock_fields.year = step_value(clock_fields.year,
				LO_ZERO, YEAR_MAX, up);
			MODE_MONTH: clock_fields.month = 4'(step_value(7'(clock_fields.month),
				LO_ONE, MONTH_MAX, up));
			MODE_DAY: clock_fields.day = 5'(step_value(7'(clock_fields.day),
				LO_ONE, DAY_MAX, up));
			MODE_WEEKDAY: clock_fields.weekday = 3'(step_value(7'(clock_fields.weekday),
				LO_ONE, WDAY_MAX, up));
			default: ;
		endcase
	endfunction

	// Applies one accepted item to the shadow state and returns the result
	// item that the core must produce for it.
	function automatic out_t apply_key_event(key_event_t ev);
		out_t r;
		action_t act;
		act = ACT_NONE;
		case (ev.cmd)
			CMD_MODE: begin
				// The last date field and the ringing mode both fall back to
				// alarm hour rather than to normal.
				if (cur_mode >= MODE_WEEKDAY)
					cur_mode = MODE_AL_HOUR;
				else
					cur_mode = mode_t'(cur_mode + 4'd1);
			end
			CMD_OK: begin
				// Committing time keeps the edited fields; every other OK
				// refreshes them from the snapshot.
				if (cur_mode >= MODE_AL_HOUR && cur_mode <= MODE_AL_SEC) begin
					act = ACT_WR_ALARM;
					clock_fields = ev.snap;
				end else if (cur_mode >= MODE_HOUR && cur_mode <= MODE_WEEKDAY) begin
					act = ACT_WR_TIME;
				end else begin
					clock_fields = ev.snap;
				end
				cur_mode = MODE_NORMAL;
			end
			CMD_MINUS: nudge_field(1'b0);
			CMD_PLUS:  nudge_field(1'b1);
			CMD_TICK: begin
				// Time edits in progress must survive the second tick.
				if (cur_mode <= MODE_AL_SEC || cur_mode == MODE_RING)
					clock_fields = ev.snap;
			end
			CMD_MATCH: cur_mode = MODE_RING;
			CMD_BUZZ: begin
				if (cur_mode == MODE_RING) begin
					buzzer_on = !buzzer_on;
					act = buzzer_on ? ACT_BUZZ_ON : ACT_BUZZ_OFF;
				end else begin
					buzzer_on = 1'b0;
					act = ACT_BUZZ_OFF;
				end
			end
			default: ;
		endcase
		r.mode = cur_mode;
		r.cal = clock_fields;
		r.alarm = alarm_fields;
		r.action = act;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic cal_t make_snapshot(int h, int m, int s, int y, int mo, int d,
		int wd);
		cal_t c;
		c.hours = 5'(h);
		c.minutes = 6'(m);
		c.seconds = 6'(s);
		c.year = 7'(y);
		c.month = 4'(mo);
		c.day = 5'(d);
		c.weekday = 3'(wd);
		return c;
	endfunction

	// Mostly calendar-valid snapshots; one in five uses the full field widths
	// so that out-of-range values get loaded and then edited.
	function automatic cal_t rand_snapshot();
		if ($urandom_range(0, 4) == 0)
			return cal_t'(36'({$urandom, $urandom}));
		return make_snapshot($urandom_range(0, 23), $urandom_range(0, 59),
			$urandom_range(0, 59), $urandom_range(0, 99), $urandom_range(1, 12),
			$urandom_range(1, 31), $urandom_range(1, 7));
	endfunction

	task automatic queue_event(logic [2:0] cmd, cal_t snap);
		key_event_t ev;
		ev.cmd = cmd;
		ev.snap = snap;
		key_events.push_back(ev);
	endtask

	// One random run of items. Most runs are well-formed sessions: walk the
	// mode key to some field, step it (now and then in long runs so every field
	// wraps), then mostly commit; or ring the alarm, toggle the buzzer and
	// silence it. The rest are snapshot ticks and plain noise.
	task automatic add_random_run();
		int kind;
		int n;
		bit up;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			if ($urandom_range(0, 1) == 0)
				queue_event(CMD_OK, rand_snapshot());
			n = $urandom_range(1, 10);
			repeat (n) queue_event(CMD_MODE, rand_snapshot());
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 12);
			up = 1'($urandom_range(0, 1));
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					queue_event(CMD_TICK, rand_snapshot());
				if ($urandom_range(0, 15) == 0)
					up = !up;
				queue_event(up ? CMD_PLUS : CMD_MINUS, rand_snapshot());
			end
			n = $urandom_range(0, 9);
			if (n < 6)
				queue_event(CMD_OK, rand_snapshot());
			else if (n < 8)
				queue_event(CMD_MODE, rand_snapshot());
		end else if (kind < 62) begin
			queue_event(CMD_MATCH, rand_snapshot());
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0)
					queue_event(CMD_TICK, rand_snapshot());
				if ($urandom_range(0, 6) == 0)
					queue_event($urandom_range(0, 1) ? CMD_PLUS : CMD_MINUS, rand_snapshot());
				queue_event(CMD_BUZZ, rand_snapshot());
			end
			queue_event($urandom_range(0, 2) == 0 ? CMD_MODE : CMD_OK, rand_snapshot());
		end else if (kind < 75) begin
			n = $urandom_range(1, 5);
			repeat (n) queue_event(CMD_TICK, rand_snapshot());
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) queue_event(3'($urandom_range(0, 7)), rand_snapshot());
		end
	endtask

	// Sender gaps: mostly none or short, a few long, and calm stretches.
	function automatic int pick_gap();
		int r;
		if (cycle_count % 700 < 150)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic string show_result(out_t v);
		return {$sformatf("mode=%0d time=%0d:%0d:%0d ", v.mode, v.cal.hours,
			v.cal.minutes, v.cal.seconds),
			$sformatf("date=%0d-%0d-%0d wd=%0d ", v.cal.year, v.cal.month,
			v.cal.day, v.cal.weekday),
			$sformatf("alarm=%0d:%0d:%0d act=%0d", v.alarm.hours, v.alarm.minutes,
			v.alarm.seconds, v.action)};
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers queued items; the prediction is made at acceptance,
	// from the values that the core actually took.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken.cmd = s_axis_tuser;
				taken.snap = s_axis_tdata[$bits(cal_t)-1:0];
				expected_displays.push_back(apply_key_event(taken));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (key_events.size() != 0) begin
					next_ev = key_events.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= next_ev.cmd;
					s_axis_tdata <= IN_DATA_W'(next_ev.snap);
					gap_left = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result against the oldest prediction and
	// drives the receiver's ready with random stalls.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(out_t)-1:0];
				results_seen++;
				if (expected_displays.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("[%0t] unexpected result: %s", $realtime, show_result(got));
				end else begin
					want = expected_displays.pop_front();
					if (got.mode != want.mode || got.cal.hours != want.cal.hours ||
						got.cal.minutes != want.cal.minutes ||
						got.cal.seconds != want.cal.seconds ||
						got.cal.year != want.cal.year || got.cal.month != want.cal.month ||
						got.cal.day != want.cal.day || got.cal.weekday != want.cal.weekday ||
						got.alarm.hours != want.alarm.hours ||
						got.alarm.minutes != want.alarm.minutes ||
						got.alarm.seconds != want.alarm.seconds ||
						got.action != want.action) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("[%0t] result %0d mismatch", $realtime, results_seen);
							$display("  expected: %s", show_result(want));
							$display("  actual:   %s", show_result(got));
						end
					end
				end
			end

			// Once, hold off for a long stretch so that both pipeline
			// registers fill and the core has to stall its input.
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_CYCLES;
			end

			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (cycle_count % 900 >= 750) begin
				m_axis_tready <= 1'b1;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:74]: m_axis_tready <= 1'b1;
					[75:96]: begin
						hold_left = $urandom_range(0, 2);
						m_axis_tready <= 1'b0;
					end
					default: begin
						hold_left = $urandom_range(10, 40);
						m_axis_tready <= 1'b0;
					end
				endcase
			end
		end
	end

	// Watchdog on a plain cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		cal_t snap_zero;
		cal_t snap_ones;
		cal_t snap_max;
		snap_zero = make_snapshot(0, 0, 0, 0, 0, 0, 0);
		snap_ones = make_snapshot(31, 63, 63, 127, 15, 31, 7);
		snap_max = make_snapshot(23, 59, 59, 99, 12, 31, 7);
		clock_fields = make_snapshot(0, 0, 0, 0, 1, 1, 1);

		// Directed part. An all-ones snapshot is loaded first so that the
		// time fields sit above their bounds when they are edited.
		queue_event(CMD_TICK, snap_ones);
		queue_event(CMD_MODE, snap_zero);   // alarm hour
		queue_event(CMD_MINUS, snap_zero);  // bottom wraps to 23
		queue_event(CMD_MODE, snap_zero);   // alarm minute
		queue_event(CMD_MINUS, snap_zero);  // bottom wraps to 59
		queue_event(CMD_PLUS, snap_zero);   // alarm minute wraps to zero, not one
		queue_event(CMD_MODE, snap_zero);   // alarm second
		queue_event(CMD_MODE, snap_zero);   // hour, holding 31
		queue_event(CMD_MINUS, snap_zero);  // above the top goes to the top
		queue_event(CMD_MODE, snap_zero);   // minute, holding 63
		queue_event(CMD_PLUS, snap_zero);   // above the top wraps to zero
		queue_event(CMD_MODE, snap_zero);
		queue_event(CMD_MODE, snap_zero);   // year
		queue_event(CMD_TICK, snap_max);    // ignored while editing time
		queue_event(CMD_MODE, snap_zero);   // month, holding 15
		queue_event(CMD_MINUS, snap_zero);
		queue_event(CMD_MODE, snap_zero);
		queue_event(CMD_MODE, snap_zero);   // weekday, holding 7
		queue_event(CMD_PLUS, snap_zero);   // top wraps to one
		queue_event(CMD_OK, snap_max);      // commit time, edits kept
		queue_event(CMD_MATCH, snap_zero);  // ringing
		queue_event(CMD_BUZZ, snap_zero);   // buzzer on
		queue_event(CMD_TICK, snap_zero);   // ringing still follows the clock
		queue_event(CMD_MODE, snap_zero);   // ringing goes to alarm hour
		queue_event(CMD_UNUSED, snap_max);
		queue_event(CMD_BUZZ, snap_max);    // outside ringing: off
		queue_event(CMD_OK, snap_max);      // commit alarm, reload clock

		while (key_events.size() < TOTAL_ITEMS)
			add_random_run();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (key_events.size() != 0 || s_axis_tvalid || expected_displays.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_displays.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
